>>> design/ifsc_pkg.sv
// Package for the infix formula syntax checker: token classes, character
// kinds, error codes and register indexes shared by the RTL files.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ifsc_pkg;

    // Class of the last token seen in the current formula.
    typedef enum logic [2:0] {
        CLS_START = 3'd0,
        CLS_VAR   = 3'd1,
        CLS_BIN   = 3'd2,
        CLS_UN    = 3'd3,
        CLS_LP    = 3'd4,
        CLS_RP    = 3'd5
    } tok_class_t;

    // Kind of one incoming character, after the precedence between classes.
    typedef enum logic [2:0] {
        KIND_SPACE = 3'd0,
        KIND_VAR   = 3'd1,
        KIND_BIN   = 3'd2,
        KIND_UN    = 3'd3,
        KIND_LP    = 3'd4,
        KIND_RP    = 3'd5,
        KIND_BAD   = 3'd6
    } char_kind_t;

    // Error codes as reported on the result channel.
    typedef enum logic [3:0] {
        ERR_NONE     = 4'd0,
        ERR_END      = 4'd1,
        ERR_VAR      = 4'd2,
        ERR_BINOP    = 4'd3,
        ERR_UNOP     = 4'd4,
        ERR_LPAREN   = 4'd5,
        ERR_SPARE_RP = 4'd6,
        ERR_RPAREN   = 4'd7,
        ERR_INVALID  = 4'd8,
        ERR_UNCLOSED = 4'd9
    } err_code_t;

    // Configuration register indexes.
    localparam logic CFG_BINARY_OPS = 1'b0;
    localparam logic CFG_UNARY_OPS  = 1'b1;

    // Reset contents of the operator tables.
    localparam logic [63:0] BINARY_OPS_RESET = 64'd93721527745574;
    localparam logic [63:0] UNARY_OPS_RESET  = 64'd1179080737;

    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;

endpackage

`default_nettype wire

>>> design/ifsc_if.sv
// Channel interfaces of the infix formula syntax checker: the character
// channel and the result channel, each with valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface ifsc_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink   (input valid, input ch, input is_end, output ready);
endinterface

interface ifsc_result_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [3:0]  error_code;
    logic [15:0] error_position;
    logic [7:0]  error_char;

    modport source (output valid, output ok, output error_code,
                    output error_position, output error_char, input ready);
    modport sink   (input valid, input ok, input error_code,
                    input error_position, input error_char, output ready);
endinterface

`default_nettype wire

>>> design/ifsc_classify.sv
// Character classifier: sorts one byte into whitespace, variable character,
// binary or unary operator, bracket or invalid. Depends on ifsc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ifsc_classify
    import ifsc_pkg::*;
#(
    parameter int OP_SLOTS = 8
)
(
    input  wire logic [7:0]  ch,
    input  wire logic [63:0] binary_ops,
    input  wire logic [63:0] unary_ops,
    output char_kind_t       kind
);

    logic is_space;
    logic is_var;
    logic bin_hit;
    logic un_hit;

    // Fixed character sets.
    always_comb
    begin
        is_space = ch inside {[8'd9:8'd13], 8'd32};
        is_var   = ch inside {[8'h61:8'h7a], [8'h30:8'h39], 8'h5f};
    end

    // Table lookups; a zero slot is unused and never matches.
    always_comb
    begin
        bin_hit = 1'b0;
        un_hit  = 1'b0;
        for (int i = 0; i < OP_SLOTS; i++)
        begin
            if (binary_ops[8*i +: 8] != 8'd0 && binary_ops[8*i +: 8] == ch)
            begin
                bin_hit = 1'b1;
            end
            if (unary_ops[8*i +: 8] != 8'd0 && unary_ops[8*i +: 8] == ch)
            begin
                un_hit = 1'b1;
            end
        end
    end

    // Precedence: space, variable, binary, unary, brackets, invalid.
    always_comb
    begin
        if (is_space)
        begin
            kind = KIND_SPACE;
        end
        else if (is_var)
        begin
            kind = KIND_VAR;
        end
        else if (bin_hit)
        begin
            kind = KIND_BIN;
        end
        else if (un_hit)
        begin
            kind = KIND_UN;
        end
        else if (ch == CHAR_LPAREN)
        begin
            kind = KIND_LP;
        end
        else if (ch == CHAR_RPAREN)
        begin
            kind = KIND_RP;
        end
        else
        begin
            kind = KIND_BAD;
        end
    end

endmodule

`default_nettype wire

>>> design/infix_formula_syntax_checker.sv
// Top level of the infix formula syntax checker: input register, token
// checking logic, sticky error state and result register.
// Depends on ifsc_pkg, ifsc_if and ifsc_classify.
//
//   Channel  Direction  Payload                                  Handshake
//   chars    in         ch[7:0], is_end                          valid/ready
//   result   out        ok, error_code[3:0], error_position[15:0],
//                       error_char[7:0]                          valid/ready
//   cfg      in         cfg_index, cfg_data[63:0]                cfg_we
//
// One character per cycle while no end item is held: an accepted item is
// registered, a character is checked against the token state in the next
// cycle, and an end item's result is registered as it leaves the input register.
// Reset clears the token state and loads the default operator tables.
// Only end items wait on the result side: while a result is not taken, an
// end item holds in the input register and the character channel stalls.
`timescale 1ns / 1ps
`default_nettype none

module infix_formula_syntax_checker
    import ifsc_pkg::*;
#(
    parameter int POS_BITS   = 16,
    parameter int DEPTH_BITS = 8,
    parameter int OP_SLOTS   = 8
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    ifsc_char_if.sink        chars,
    ifsc_result_if.source    result,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam logic [POS_BITS-1:0]   POS_MAX   = {POS_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    // Configuration registers.
    logic [63:0] binary_ops_reg;
    logic [63:0] unary_ops_reg;

    // Input register.
    logic        in_valid_reg;
    logic [7:0]  in_ch_reg;
    logic        in_end_reg;

    // Token state.
    tok_class_t            class_reg,    class_next;
    logic                  run_reg,      run_next;
    logic [DEPTH_BITS-1:0] depth_reg,    depth_next;
    logic [POS_BITS-1:0]   pos_reg,      pos_next;
    err_code_t             err_code_reg, err_code_next;
    logic [POS_BITS-1:0]   err_pos_reg,  err_pos_next;
    logic [7:0]            err_char_reg, err_char_next;

    // Result register.
    logic        out_valid_reg;
    logic        out_ok_reg;
    err_code_t   out_code_reg;
    logic [15:0] out_pos_reg;
    logic [7:0]  out_char_reg;

    char_kind_t          kind;
    logic                advance;
    logic                needs_operand;
    logic                after_operand;
    err_code_t           final_code;
    logic [POS_BITS-1:0] final_pos;
    logic [7:0]          final_char;
    logic [POS_BITS+15:0] final_pos_ext;

    // An end item may only leave the input register when the result slot
    // is free or being emptied.
    assign advance = in_valid_reg && (!in_end_reg || !out_valid_reg || result.ready);
    assign chars.ready = !in_valid_reg || advance;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            binary_ops_reg <= BINARY_OPS_RESET;
            unary_ops_reg  <= UNARY_OPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BINARY_OPS: binary_ops_reg <= cfg_data;
                CFG_UNARY_OPS:  unary_ops_reg  <= cfg_data;
                default:        binary_ops_reg <= binary_ops_reg;
            endcase
        end
    end

    // Input register: valid flag under reset, payload without.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (chars.ready)
        begin
            in_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            in_ch_reg  <= chars.ch;
            in_end_reg <= chars.is_end;
        end
    end

    ifsc_classify #(
        .OP_SLOTS (OP_SLOTS)
    ) u_classify (
        .ch         (in_ch_reg),
        .binary_ops (binary_ops_reg),
        .unary_ops  (unary_ops_reg),
        .kind       (kind)
    );

    // Adjacency rules on the previous token class.
    assign needs_operand = class_reg == CLS_START || class_reg == CLS_BIN
                        || class_reg == CLS_UN || class_reg == CLS_LP;
    assign after_operand = class_reg == CLS_VAR || class_reg == CLS_RP;

    // Next token state.
    always_comb
    begin
        class_next    = class_reg;
        run_next      = run_reg;
        depth_next    = depth_reg;
        pos_next      = pos_reg;
        err_code_next = err_code_reg;
        err_pos_next  = err_pos_reg;
        err_char_next = err_char_reg;
        if (advance && !in_end_reg)
        begin
            if (err_code_reg == ERR_NONE)
            begin
                // Any token other than a variable character ends a run.
                if (kind != KIND_VAR)
                begin
                    run_next = 1'b0;
                end
                err_pos_next  = pos_reg;
                err_char_next = in_ch_reg;
                case (kind)
                    KIND_SPACE:
                    begin
                        run_next = 1'b0;
                    end
                    KIND_VAR:
                    begin
                        if (!run_reg)
                        begin
                            if (after_operand)
                            begin
                                err_code_next = ERR_VAR;
                            end
                            else
                            begin
                                class_next = CLS_VAR;
                                run_next   = 1'b1;
                            end
                        end
                    end
                    KIND_BIN:
                    begin
                        if (needs_operand)
                        begin
                            err_code_next = ERR_BINOP;
                        end
                        else
                        begin
                            class_next = CLS_BIN;
                        end
                    end
                    KIND_UN:
                    begin
                        if (after_operand)
                        begin
                            err_code_next = ERR_UNOP;
                        end
                        else
                        begin
                            class_next = CLS_UN;
                        end
                    end
                    KIND_LP:
                    begin
                        if (after_operand)
                        begin
                            err_code_next = ERR_LPAREN;
                        end
                        else
                        begin
                            if (depth_reg != DEPTH_MAX)
                            begin
                                depth_next = depth_reg + 1'b1;
                            end
                            class_next = CLS_LP;
                        end
                    end
                    KIND_RP:
                    begin
                        if (depth_reg == '0)
                        begin
                            err_code_next = ERR_SPARE_RP;
                        end
                        else if (needs_operand)
                        begin
                            err_code_next = ERR_RPAREN;
                        end
                        else
                        begin
                            depth_next = depth_reg - 1'b1;
                            class_next = CLS_RP;
                        end
                    end
                    default:
                    begin
                        err_code_next = ERR_INVALID;
                    end
                endcase
                // The stored position and character only matter with an error.
                if (err_code_next == ERR_NONE)
                begin
                    err_pos_next  = err_pos_reg;
                    err_char_next = err_char_reg;
                end
            end
            // Position saturates at its maximum.
            if (pos_reg != POS_MAX)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        else if (advance && in_end_reg)
        begin
            // An end item starts a new formula.
            class_next    = CLS_START;
            run_next      = 1'b0;
            depth_next    = '0;
            pos_next      = '0;
            err_code_next = ERR_NONE;
            err_pos_next  = '0;
            err_char_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg    <= CLS_START;
            run_reg      <= 1'b0;
            depth_reg    <= '0;
            pos_reg      <= '0;
            err_code_reg <= ERR_NONE;
            err_pos_reg  <= '0;
            err_char_reg <= 8'd0;
        end
        else
        begin
            class_reg    <= class_next;
            run_reg      <= run_next;
            depth_reg    <= depth_next;
            pos_reg      <= pos_next;
            err_code_reg <= err_code_next;
            err_pos_reg  <= err_pos_next;
            err_char_reg <= err_char_next;
        end
    end

    // Verdict at the end of a formula: a sticky error wins, then an
    // unfinished expression, then an unclosed bracket.
    always_comb
    begin
        final_pos  = pos_reg;
        final_char = 8'd0;
        if (err_code_reg != ERR_NONE)
        begin
            final_code = err_code_reg;
            final_pos  = err_pos_reg;
            final_char = err_char_reg;
        end
        else if (needs_operand)
        begin
            final_code = ERR_END;
        end
        else if (depth_reg != '0)
        begin
            final_code = ERR_UNCLOSED;
        end
        else
        begin
            final_code = ERR_NONE;
        end
    end

    assign final_pos_ext = {16'd0, final_pos};

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_end_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_end_reg)
        begin
            out_ok_reg   <= final_code == ERR_NONE;
            out_code_reg <= final_code;
            out_pos_reg  <= (final_code == ERR_NONE) ? 16'd0 : final_pos_ext[15:0];
            out_char_reg <= (final_code == ERR_NONE) ? 8'd0 : final_char;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.ok             = out_ok_reg;
    assign result.error_code     = out_code_reg;
    assign result.error_position = out_pos_reg;
    assign result.error_char     = out_char_reg;

`ifndef SYNTHESIS
    // A new result only follows an end item leaving the input register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(advance && in_end_reg))
        else $error("result appeared without an end item");

    // The ok flag agrees with the error code.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_ok_reg == (out_code_reg == ERR_NONE)))
        else $error("ok flag and error code disagree");

    // A valid formula reports no position and no character.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ok_reg) |-> (out_pos_reg == 16'd0 && out_char_reg == 8'd0))
        else $error("ok result carries error details");

    // Once an error is held, later characters leave the token class, depth and error code alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !in_end_reg && err_code_reg != ERR_NONE)
        |=> ($stable(class_reg) && $stable(depth_reg) && $stable(err_code_reg)))
        else $error("token state moved after a sticky error");
`endif

endmodule

`default_nettype wire

>>> tb/infix_formula_syntax_checker_test.sv
// Self-checking testbench for the infix formula syntax checker: random and
// directed formulas, operator table changes and a verdict check on every end.
// Depends on ifsc_pkg, ifsc_if and the infix_formula_syntax_checker RTL.
`timescale 1ns / 1ps

module infix_formula_syntax_checker_test
    import ifsc_pkg::*;
();

    // One item on the character channel, or a marker that makes the driver
    // wait until every verdict owed so far has arrived.
    typedef struct packed {
        logic       hold;
        logic [7:0] ch;
        logic       is_end;
    } char_item_t;

    typedef struct packed {
        logic        ok;
        err_code_t   code;
        logic [15:0] pos;
        logic [7:0]  chr;
    } formula_verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic        cfg_index;
    logic [63:0] cfg_data;

    ifsc_char_if   chars_bus ();
    ifsc_result_if result_bus ();

    infix_formula_syntax_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_bus),
        .result    (result_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    char_item_t       char_queue[$];
    formula_verdict_t verdicts_due[$];
    int               mismatches = 0;
    int               verdicts_seen = 0;
    int               hold_left = 0;
    bit               hold_done = 1'b0;
    bit               no_idle = 1'b0;

    // Operator tables and token state as the checker should hold them.
    logic [63:0] bin_ops = BINARY_OPS_RESET;
    logic [63:0] un_ops = UNARY_OPS_RESET;
    tok_class_t  tok_prev = CLS_START;
    logic        in_word = 1'b0;
    logic [7:0]  paren_depth = 8'd0;
    logic [15:0] char_idx = 16'd0;
    err_code_t   first_err = ERR_NONE;
    logic [15:0] first_err_pos = 16'd0;
    logic [7:0]  first_err_chr = 8'd0;

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic in_ops(logic [63:0] tab, logic [7:0] c);
        for (int i = 0; i < 8; i++)
        begin
            if (tab[8*i +: 8] != 8'd0 && tab[8*i +: 8] == c)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // Character class, with whitespace and variable characters taking
    // precedence over the binary table, then the unary table, then brackets.
    function automatic char_kind_t kind_of(logic [7:0] c);
        if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13))
            return KIND_SPACE;
        if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "_")
            return KIND_VAR;
        if (in_ops(bin_ops, c))
            return KIND_BIN;
        if (in_ops(un_ops, c))
            return KIND_UN;
        if (c == CHAR_LPAREN)
            return KIND_LP;
        if (c == CHAR_RPAREN)
            return KIND_RP;
        return KIND_BAD;
    endfunction

    function automatic logic needs_operand(tok_class_t t);
        return t inside {CLS_START, CLS_BIN, CLS_UN, CLS_LP};
    endfunction

    function automatic logic follows_operand(tok_class_t t);
        return t inside {CLS_VAR, CLS_RP};
    endfunction

    function automatic void raise_error(err_code_t code, logic [7:0] c);
        first_err     = code;
        first_err_pos = char_idx;
        first_err_chr = c;
    endfunction

    // Advance the token state by one accepted item; an end item yields the
    // verdict for the formula and starts a fresh one.
    function automatic void predict_item(logic is_end, logic [7:0] c);
        formula_verdict_t v;
        if (!is_end)
        begin
            if (first_err == ERR_NONE)
            begin
                case (kind_of(c))
                    KIND_SPACE:
                        in_word = 1'b0;
                    KIND_VAR:
                        if (!in_word)
                        begin
                            if (follows_operand(tok_prev))
                                raise_error(ERR_VAR, c);
                            else
                            begin
                                tok_prev = CLS_VAR;
                                in_word  = 1'b1;
                            end
                        end
                    KIND_BIN:
                    begin
                        in_word = 1'b0;
                        if (needs_operand(tok_prev))
                            raise_error(ERR_BINOP, c);
                        else
                            tok_prev = CLS_BIN;
                    end
                    KIND_UN:
                    begin
                        in_word = 1'b0;
                        if (follows_operand(tok_prev))
                            raise_error(ERR_UNOP, c);
                        else
                            tok_prev = CLS_UN;
                    end
                    KIND_LP:
                    begin
                        in_word = 1'b0;
                        if (follows_operand(tok_prev))
                            raise_error(ERR_LPAREN, c);
                        else
                        begin
                            if (paren_depth != 8'hFF)
                                paren_depth = paren_depth + 8'd1;
                            tok_prev = CLS_LP;
                        end
                    end
                    KIND_RP:
                    begin
                        in_word = 1'b0;
                        if (paren_depth == 8'd0)
                            raise_error(ERR_SPARE_RP, c);
                        else if (needs_operand(tok_prev))
                            raise_error(ERR_RPAREN, c);
                        else
                        begin
                            paren_depth = paren_depth - 8'd1;
                            tok_prev    = CLS_RP;
                        end
                    end
                    default:
                    begin
                        in_word = 1'b0;
                        raise_error(ERR_INVALID, c);
                    end
                endcase
            end
            if (char_idx != 16'hFFFF)
                char_idx = char_idx + 16'd1;
        end
        else
        begin
            if (first_err == ERR_NONE)
            begin
                if (needs_operand(tok_prev))
                    raise_error(ERR_END, 8'd0);
                else if (paren_depth != 8'd0)
                    raise_error(ERR_UNCLOSED, 8'd0);
            end
            v.ok   = (first_err == ERR_NONE);
            v.code = first_err;
            v.pos  = v.ok ? 16'd0 : first_err_pos;
            v.chr  = v.ok ? 8'd0 : first_err_chr;
            verdicts_due.push_back(v);
            tok_prev      = CLS_START;
            in_word       = 1'b0;
            paren_depth   = 8'd0;
            char_idx      = 16'd0;
            first_err     = ERR_NONE;
            first_err_pos = 16'd0;
            first_err_chr = 8'd0;
        end
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    function automatic void push_char(logic [7:0] c);
        char_queue.push_back('{hold: 1'b0, ch: c, is_end: 1'b0});
    endfunction

    // The character on an end item carries nothing, so it is left random.
    function automatic void push_end();
        char_queue.push_back('{hold: 1'b0, ch: 8'($urandom_range(0, 255)), is_end: 1'b1});
    endfunction

    function automatic void push_hold();
        char_queue.push_back('{hold: 1'b1, ch: 8'd0, is_end: 1'b0});
    endfunction

    function automatic void push_formula(string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
        push_end();
    endfunction

    // A usable operator character of the wanted class from a table, or zero.
    function automatic logic [7:0] pick_op(logic [63:0] tab, char_kind_t k);
        int         first;
        logic [7:0] c;
        first = $urandom_range(0, 7);
        for (int i = 0; i < 8; i++)
        begin
            c = tab[8*((first + i) % 8) +: 8];
            if (c != 8'd0 && kind_of(c) == k)
                return c;
        end
        return 8'd0;
    endfunction

    function automatic logic [7:0] pick_space();
        int r;
        r = $urandom_range(8, 13);
        return (r == 8) ? 8'd32 : 8'(r);
    endfunction

    function automatic logic [7:0] pick_word_char();
        int r;
        r = $urandom_range(0, 36);
        if (r < 26)
            return 8'("a" + r);
        if (r < 36)
            return 8'("0" + r - 26);
        return "_";
    endfunction

    function automatic logic [63:0] random_table();
        string       op_set;
        logic [63:0] tab;
        int          r;
        op_set = "&|^>=U!XGF~-+*/<%@#$()";
        tab = 64'd0;
        for (int i = 0; i < 8; i++)
        begin
            r = $urandom_range(0, 9);
            if (r < 3)
                tab[8*i +: 8] = 8'd0;
            else if (r == 3)
                tab[8*i +: 8] = 8'($urandom_range(0, 255));
            else
                tab[8*i +: 8] = op_set[$urandom_range(0, op_set.len() - 1)];
        end
        return tab;
    endfunction

    // Queue one formula: well formed (0), one character damaged (1) or
    // random bytes (2). Returns the number of items queued.
    function automatic int add_formula(int style);
        logic [7:0] text[$];
        logic [7:0] op;
        bit         need;
        bit         done;
        bit         parens;
        int         depth;
        int         n_bin;
        int         limit;
        int         r;
        int         at;
        if (style == 2)
        begin
            repeat ($urandom_range(0, 8))
                text.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            need   = 1'b1;
            done   = 1'b0;
            depth  = 0;
            n_bin  = 0;
            limit  = $urandom_range(0, 6);
            parens = (kind_of(CHAR_LPAREN) == KIND_LP) && (kind_of(CHAR_RPAREN) == KIND_RP);
            while (!done)
            begin
                r = $urandom_range(0, 9);
                if (need)
                begin
                    op = pick_op(un_ops, KIND_UN);
                    if (r < 2 && op != 8'd0)
                        text.push_back(op);
                    else if (r < 4 && parens && depth < 4)
                    begin
                        text.push_back(CHAR_LPAREN);
                        depth++;
                    end
                    else
                    begin
                        repeat ($urandom_range(1, 3))
                            text.push_back(pick_word_char());
                        need = 1'b0;
                    end
                end
                else
                begin
                    op = pick_op(bin_ops, KIND_BIN);
                    if (n_bin < limit && op != 8'd0 && r < 7)
                    begin
                        text.push_back(op);
                        n_bin++;
                        need = 1'b1;
                    end
                    else if (depth > 0)
                    begin
                        text.push_back(CHAR_RPAREN);
                        depth--;
                    end
                    else
                        done = 1'b1;
                end
                if ($urandom_range(0, 3) == 0)
                    text.push_back(pick_space());
            end
            // Damage one character: overwrite, drop, double or swap in a bracket.
            if (style == 1 && text.size() != 0)
            begin
                at = $urandom_range(0, text.size() - 1);
                case ($urandom_range(0, 3))
                    0: text[at] = 8'($urandom_range(0, 255));
                    1: text.delete(at);
                    2: text.insert(at, text[at]);
                    default: text[at] = $urandom_range(0, 1) ? CHAR_LPAREN : CHAR_RPAREN;
                endcase
            end
        end
        foreach (text[i])
            push_char(text[i]);
        push_end();
        return text.size() + 1;
    endfunction

    function automatic void add_random(int n);
        int added;
        int r;
        added = 0;
        while (added < n)
        begin
            r = $urandom_range(0, 99);
            added += add_formula((r < 70) ? 0 : (r < 90) ? 1 : 2);
            if ($urandom_range(0, 39) == 0)
                push_hold();
        end
    endfunction

    task automatic write_reg(logic idx, logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BINARY_OPS)
            bin_ops = val;
        else
            un_ops = val;
    endtask

    // Wait until every item is taken and every verdict is in, then let the
    // pipeline settle before the tables may change.
    task automatic drain();
        @(negedge clk);
        while (char_queue.size() != 0 || chars_bus.valid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (6)
            @(posedge clk);
    endtask

    // Character driver: offers queued items and predicts on each acceptance.
    always @(posedge clk)
    begin : drive_chars
        char_item_t nxt;
        logic       give;
        give = 1'b0;
        nxt  = '0;
        if (!rst_n)
            chars_bus.valid <= 1'b0;
        else
        begin
            if (chars_bus.valid && chars_bus.ready)
                predict_item(chars_bus.is_end, chars_bus.ch);
            if (!chars_bus.valid || chars_bus.ready)
            begin
                if (char_queue.size() != 0 && char_queue[0].hold)
                begin
                    if (verdicts_due.size() == 0)
                        void'(char_queue.pop_front());
                end
                else if (char_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 21))
                begin
                    nxt  = char_queue.pop_front();
                    give = 1'b1;
                end
                chars_bus.valid <= give;
                if (give)
                begin
                    chars_bus.ch     <= nxt.ch;
                    chars_bus.is_end <= nxt.is_end;
                end
            end
        end
    end

    // Verdict monitor: checks each accepted verdict against the oldest one due.
    always @(posedge clk)
    begin : check_verdicts
        formula_verdict_t want;
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
            begin
                verdicts_seen <= verdicts_seen + 1;
                if (verdicts_due.size() == 0)
                    report_mismatch("verdict with none due, code",
                                    16'(result_bus.error_code), 16'd0);
                else
                begin
                    want = verdicts_due.pop_front();
                    if (result_bus.ok !== want.ok)
                        report_mismatch("ok", 16'(result_bus.ok), 16'(want.ok));
                    if (result_bus.error_code !== want.code)
                        report_mismatch("error_code", 16'(result_bus.error_code),
                                        16'(want.code));
                    if (result_bus.error_position !== want.pos)
                        report_mismatch("error_position", result_bus.error_position, want.pos);
                    if (result_bus.error_char !== want.chr)
                        report_mismatch("error_char", 16'(result_bus.error_char),
                                        16'(want.chr));
                end
            end
            result_bus.ready <= (hold_left == 0) && (no_idle || $urandom_range(0, 99) >= 21);
        end
    end

    // One long hold-off on the verdict side so that the checker backs up.
    always @(posedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (!hold_done && verdicts_seen >= 40)
        begin
            hold_left <= 120;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Stimulus sequence.
    initial
    begin
        chars_bus.valid  = 1'b0;
        chars_bus.ch     = 8'd0;
        chars_bus.is_end = 1'b0;
        result_bus.ready = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_BINARY_OPS;
        cfg_data         = 64'd0;
        repeat (8)
            @(posedge clk);
        rst_n <= 1'b1;

        // Default tables: each error kind, whitespace, zero byte, top byte.
        push_formula("a&b");
        push_formula("");
        push_formula("!a");
        push_formula("(a|b)^c");
        push_formula("a b");
        push_formula("&a");
        push_formula("a!");
        push_hold();
        push_formula("a(");
        push_formula(")");
        push_formula("(a&)");
        push_formula("a#");
        push_formula("(a");
        push_formula("a&");
        push_char("a");
        push_char(8'd0);
        push_end();
        push_char(8'hFF);
        push_end();
        push_char("a");
        for (int c = 9; c <= 13; c++)
            push_char(8'(c));
        push_char(8'd32);
        push_char("&");
        push_char(8'd32);
        push_formula("b");
        push_formula("x_9 > y0");
        push_formula("a b ) #");
        push_formula("a=bUc");
        push_formula("XGFa");
        push_formula("G(a>b)");
        drain();

        // Brackets claimed by the tables, and a variable character in one.
        write_reg(CFG_BINARY_OPS, 64'h0000_0000_0000_2826);
        write_reg(CFG_UNARY_OPS, 64'h0000_0000_0061_2921);
        push_formula("a(b");
        push_formula(")a");
        push_formula("!)a&b");
        push_formula("a|b");
        push_formula("(a");
        push_formula("a)");
        push_formula("a");
        drain();

        // Extreme tables: all slots at the top byte, and all slots unused.
        write_reg(CFG_BINARY_OPS, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_UNARY_OPS, 64'd0);
        push_char("a");
        push_char(8'hFF);
        push_formula("b");
        push_formula("!a");
        push_char(8'd0);
        push_end();
        drain();
        write_reg(CFG_BINARY_OPS, 64'd0);
        write_reg(CFG_UNARY_OPS, 64'hFFFF_FFFF_FFFF_FFFF);
        push_formula("a&b");
        push_char(8'hFF);
        push_formula("a");
        drain();

        // Random formulas under random and default tables.
        write_reg(CFG_BINARY_OPS, random_table());
        write_reg(CFG_UNARY_OPS, random_table());
        add_random(100);
        drain();
        write_reg(CFG_BINARY_OPS, BINARY_OPS_RESET);
        write_reg(CFG_UNARY_OPS, UNARY_OPS_RESET);
        no_idle = 1'b1;
        add_random(100);
        drain();
        no_idle = 1'b0;
        write_reg(CFG_UNARY_OPS, random_table());
        write_reg(CFG_BINARY_OPS, random_table());
        add_random(100);
        drain();

        repeat (10)
            @(posedge clk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
